// ===== hw/rtl/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

   // Width of every operand and result field on the ports.
   localparam int FIELD_W        = 32;
   localparam int TYPE_W         = 3;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [TYPE_W-1:0] {
      OP_ADD = 3'd0,
      OP_SUB = 3'd1,
      OP_MUL = 3'd2,
      OP_DIV = 3'd3,
      OP_NEG = 3'd4,
      OP_MAG = 3'd5,
      OP_INV = 3'd6
   } op_type;

   // Per-item control bits that travel with the data down the divider chain.
   typedef struct packed {
      logic valid;
      logic div;
      logic dz;
      logic ovf;
      logic neg_re;
      logic neg_im;
      logic ovq_re;
      logic ovq_im;
   } ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cau_prep.sv =====
`default_nettype none

module cau_prep
   import cau_pkg::*;
#(
   parameter int OPW       = DATA_WIDTH_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  op_type                    op_i,
   input  logic signed [OPW-1:0]     a_re_i,
   input  logic signed [OPW-1:0]     a_im_i,
   input  logic signed [OPW-1:0]     b_re_i,
   input  logic signed [OPW-1:0]     b_im_i,
   output ctl_type                   ctl_o,
   output logic [2*OPW-1:0]          den_o,
   output logic [2*OPW-1:0]          rem_re_o,
   output logic [2*OPW-1:0]          rem_im_o,
   output logic [OPW:0]              xq_re_o,
   output logic [OPW:0]              xq_im_o,
   output logic signed [OPW-1:0]     res_re_o,
   output logic signed [OPW-1:0]     res_im_o
);

   localparam int MW = 2 * OPW;
   localparam int SW = MW + 1;
   localparam int QB = OPW + 1;
   localparam int XW = 3 * OPW + 2 * FRAC_BITS + 1;
   localparam int HW = XW - QB;
   localparam logic [MW-1:0] HALF = MW'(1) << (OPW - 1);

   // Saturate a sign and magnitude to the operand range; the top bit is the overflow flag.
   function automatic logic [OPW:0] sat_fn(input logic neg, input logic [MW-1:0] mag);
      logic [OPW:0] r;
      if (!neg) begin
         if (mag > HALF - MW'(1)) begin
            r = {1'b1, OPW'(HALF - MW'(1))};
         end else begin
            r = {1'b0, mag[OPW-1:0]};
         end
      end else begin
         if (mag > HALF) begin
            r = {1'b1, OPW'(HALF)};
         end else begin
            r = {1'b0, OPW'(MW'(0) - mag)};
         end
      end
      return r;
   endfunction

   // Stage A: operand capture.
   logic                  va_ff;
   op_type                op_a_ff;
   logic signed [OPW-1:0] ar_a_ff, ai_a_ff, br_a_ff, bi_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else begin
         va_ff <= in_valid;
      end
      op_a_ff <= op_i;
      ar_a_ff <= a_re_i;
      ai_a_ff <= a_im_i;
      br_a_ff <= b_re_i;
      bi_a_ff <= b_im_i;
   end

   // Stage B: six products in parallel.
   logic signed [OPW-1:0] sq_x, sq_y;
   logic signed [MW-1:0]  p_rr_in, p_ii_in, p_ri_in, p_ir_in, p_d0_in, p_d1_in;

   always_comb begin
      if (op_a_ff == OP_MAG || op_a_ff == OP_INV) begin
         sq_x = ar_a_ff;
         sq_y = ai_a_ff;
      end else begin
         sq_x = br_a_ff;
         sq_y = bi_a_ff;
      end
   end

   assign p_rr_in = ar_a_ff * br_a_ff;
   assign p_ii_in = ai_a_ff * bi_a_ff;
   assign p_ri_in = ar_a_ff * bi_a_ff;
   assign p_ir_in = ai_a_ff * br_a_ff;
   assign p_d0_in = sq_x * sq_x;
   assign p_d1_in = sq_y * sq_y;

   logic                  vb_ff;
   op_type                op_b_ff;
   logic signed [OPW-1:0] ar_b_ff, ai_b_ff, br_b_ff, bi_b_ff;
   logic signed [MW-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_d0_ff, p_d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
      end
      op_b_ff <= op_a_ff;
      ar_b_ff <= ar_a_ff;
      ai_b_ff <= ai_a_ff;
      br_b_ff <= br_a_ff;
      bi_b_ff <= bi_a_ff;
      p_rr_ff <= p_rr_in;
      p_ii_ff <= p_ii_in;
      p_ri_ff <= p_ri_in;
      p_ir_ff <= p_ir_in;
      p_d0_ff <= p_d0_in;
      p_d1_ff <= p_d1_in;
   end

   // Stage C: sums and differences.
   logic signed [SW-1:0] v_re_in, v_im_in, num_re_in, num_im_in;
   logic [MW-1:0]        den_in;

   always_comb begin
      v_re_in   = '0;
      v_im_in   = '0;
      num_re_in = '0;
      num_im_in = '0;
      case (op_b_ff)
         OP_ADD: begin
            v_re_in = SW'(ar_b_ff) + SW'(br_b_ff);
            v_im_in = SW'(ai_b_ff) + SW'(bi_b_ff);
         end
         OP_SUB: begin
            v_re_in = SW'(ar_b_ff) - SW'(br_b_ff);
            v_im_in = SW'(ai_b_ff) - SW'(bi_b_ff);
         end
         OP_MUL: begin
            v_re_in = SW'(p_rr_ff) - SW'(p_ii_ff);
            v_im_in = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         OP_DIV: begin
            num_re_in = SW'(p_rr_ff) + SW'(p_ii_ff);
            num_im_in = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
         OP_NEG: begin
            v_re_in = -SW'(ar_b_ff);
            v_im_in = -SW'(ai_b_ff);
         end
         OP_MAG: begin
            v_re_in = SW'(p_d0_ff) + SW'(p_d1_ff);
         end
         OP_INV: begin
            num_re_in = SW'(ar_b_ff);
            num_im_in = -SW'(ai_b_ff);
         end
         default: begin
         end
      endcase
   end

   // Both squares are non-negative, so their sum fits the unsigned width.
   assign den_in = MW'($unsigned(p_d0_ff) + $unsigned(p_d1_ff));

   logic                 vc_ff;
   op_type               op_c_ff;
   logic signed [SW-1:0] v_re_ff, v_im_ff, num_re_ff, num_im_ff;
   logic [MW-1:0]        den_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vc_ff <= 1'b0;
      end else begin
         vc_ff <= vb_ff;
      end
      op_c_ff   <= op_b_ff;
      v_re_ff   <= v_re_in;
      v_im_ff   <= v_im_in;
      num_re_ff <= num_re_in;
      num_im_ff <= num_im_in;
      den_c_ff  <= den_in;
   end

   // Stage D: magnitudes, truncating fraction shift and saturation of the direct results.
   logic [SW-1:0] u_re, u_im, un_re, un_im;
   logic [MW-1:0] m_re, m_im;
   logic          shf;
   logic [OPW:0]  s_re, s_im;

   assign shf   = (op_c_ff == OP_MUL) || (op_c_ff == OP_MAG);
   assign u_re  = v_re_ff[SW-1] ? SW'(-v_re_ff) : SW'(v_re_ff);
   assign u_im  = v_im_ff[SW-1] ? SW'(-v_im_ff) : SW'(v_im_ff);
   assign un_re = num_re_ff[SW-1] ? SW'(-num_re_ff) : SW'(num_re_ff);
   assign un_im = num_im_ff[SW-1] ? SW'(-num_im_ff) : SW'(num_im_ff);
   assign m_re  = shf ? (u_re[MW-1:0] >> FRAC_BITS) : u_re[MW-1:0];
   assign m_im  = shf ? (u_im[MW-1:0] >> FRAC_BITS) : u_im[MW-1:0];
   assign s_re  = sat_fn(v_re_ff[SW-1], m_re);
   assign s_im  = sat_fn(v_im_ff[SW-1], m_im);

   logic                  vd_ff, div_d_ff, inv_d_ff, ovf_d_ff;
   logic signed [OPW-1:0] res_re_d_ff, res_im_d_ff;
   logic                  nneg_re_ff, nneg_im_ff;
   logic [MW-1:0]         nmag_re_ff, nmag_im_ff, den_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vd_ff <= 1'b0;
      end else begin
         vd_ff <= vc_ff;
      end
      div_d_ff    <= (op_c_ff == OP_DIV) || (op_c_ff == OP_INV);
      inv_d_ff    <= (op_c_ff == OP_INV);
      ovf_d_ff    <= s_re[OPW] | s_im[OPW];
      res_re_d_ff <= s_re[OPW-1:0];
      res_im_d_ff <= s_im[OPW-1:0];
      nneg_re_ff  <= num_re_ff[SW-1];
      nneg_im_ff  <= num_im_ff[SW-1];
      nmag_re_ff  <= un_re[MW-1:0];
      nmag_im_ff  <= un_im[MW-1:0];
      den_d_ff    <= den_c_ff;
   end

   // Stage E: scaled dividend, early quotient overflow check, first partial remainder.
   logic [XW-1:0] x_re, x_im;
   logic [HW-1:0] hi_re, hi_im;
   ctl_type       ctl_in;

   assign x_re  = inv_d_ff ? (XW'(nmag_re_ff) << (2 * FRAC_BITS))
                           : (XW'(nmag_re_ff) << FRAC_BITS);
   assign x_im  = inv_d_ff ? (XW'(nmag_im_ff) << (2 * FRAC_BITS))
                           : (XW'(nmag_im_ff) << FRAC_BITS);
   assign hi_re = x_re[XW-1:QB];
   assign hi_im = x_im[XW-1:QB];

   always_comb begin
      ctl_in.valid  = vd_ff;
      ctl_in.div    = div_d_ff;
      ctl_in.dz     = div_d_ff && (den_d_ff == '0);
      ctl_in.ovf    = ovf_d_ff;
      ctl_in.neg_re = nneg_re_ff;
      ctl_in.neg_im = nneg_im_ff;
      ctl_in.ovq_re = hi_re >= HW'(den_d_ff);
      ctl_in.ovq_im = hi_im >= HW'(den_d_ff);
   end

   ctl_type               ctl_ff;
   logic [MW-1:0]         den_e_ff, rem_re_ff, rem_im_ff;
   logic [QB-1:0]         xq_re_ff, xq_im_ff;
   logic signed [OPW-1:0] res_re_e_ff, res_im_e_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
      end
      den_e_ff    <= den_d_ff;
      rem_re_ff   <= hi_re[MW-1:0];
      rem_im_ff   <= hi_im[MW-1:0];
      xq_re_ff    <= x_re[QB-1:0];
      xq_im_ff    <= x_im[QB-1:0];
      res_re_e_ff <= res_re_d_ff;
      res_im_e_ff <= res_im_d_ff;
   end

   assign ctl_o    = ctl_ff;
   assign den_o    = den_e_ff;
   assign rem_re_o = rem_re_ff;
   assign rem_im_o = rem_im_ff;
   assign xq_re_o  = xq_re_ff;
   assign xq_im_o  = xq_im_ff;
   assign res_re_o = res_re_e_ff;
   assign res_im_o = res_im_e_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cau_cell.sv =====
`default_nettype none

module cau_cell
   import cau_pkg::*;
#(
   parameter int OPW = DATA_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl_i,
   input  logic [2*OPW-1:0]      den_i,
   input  logic [2*OPW-1:0]      rem_re_i,
   input  logic [2*OPW-1:0]      rem_im_i,
   input  logic [OPW:0]          xq_re_i,
   input  logic [OPW:0]          xq_im_i,
   input  logic signed [OPW-1:0] res_re_i,
   input  logic signed [OPW-1:0] res_im_i,
   output ctl_type               ctl_o,
   output logic [2*OPW-1:0]      den_o,
   output logic [2*OPW-1:0]      rem_re_o,
   output logic [2*OPW-1:0]      rem_im_o,
   output logic [OPW:0]          xq_re_o,
   output logic [OPW:0]          xq_im_o,
   output logic signed [OPW-1:0] res_re_o,
   output logic signed [OPW-1:0] res_im_o
);

   localparam int MW = 2 * OPW;
   localparam int QB = OPW + 1;

   // One restoring step for each part: bring down the next dividend bit, subtract if it fits,
   // and shift the quotient bit in where the dividend bit left.
   logic [MW:0]   trial_re, trial_im, den_x;
   logic          ge_re, ge_im;
   logic [MW-1:0] rem_re_in, rem_im_in;
   logic [QB-1:0] xq_re_in, xq_im_in;

   assign den_x     = {1'b0, den_i};
   assign trial_re  = {rem_re_i, xq_re_i[QB-1]};
   assign trial_im  = {rem_im_i, xq_im_i[QB-1]};
   assign ge_re     = trial_re >= den_x;
   assign ge_im     = trial_im >= den_x;
   assign rem_re_in = ge_re ? MW'(trial_re - den_x) : MW'(trial_re);
   assign rem_im_in = ge_im ? MW'(trial_im - den_x) : MW'(trial_im);
   assign xq_re_in  = {xq_re_i[QB-2:0], ge_re};
   assign xq_im_in  = {xq_im_i[QB-2:0], ge_im};

   ctl_type               ctl_ff;
   logic [MW-1:0]         den_ff, rem_re_ff, rem_im_ff;
   logic [QB-1:0]         xq_re_ff, xq_im_ff;
   logic signed [OPW-1:0] res_re_ff, res_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff <= ctl_i;
      end
      den_ff    <= den_i;
      rem_re_ff <= rem_re_in;
      rem_im_ff <= rem_im_in;
      xq_re_ff  <= xq_re_in;
      xq_im_ff  <= xq_im_in;
      res_re_ff <= res_re_i;
      res_im_ff <= res_im_i;
   end

   assign ctl_o    = ctl_ff;
   assign den_o    = den_ff;
   assign rem_re_o = rem_re_ff;
   assign rem_im_o = rem_im_ff;
   assign xq_re_o  = xq_re_ff;
   assign xq_im_o  = xq_im_ff;
   assign res_re_o = res_re_ff;
   assign res_im_o = res_im_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arith_unit_core.sv =====
// Complex-number ALU on signed fixed-point operands (Q16.16 by default).
// Input channel: a transfer happens at a rising edge where start is high and busy is low.
// The transfer carries the operation code (req_type) and the two operands a and b. The
// operations are add, subtract, multiply, divide, negate a, squared magnitude of a and
// inverse of a (conjugate of a over its squared magnitude).
// Result channel: rsp_valid is high for exactly one cycle per transfer, together with the
// real and imaginary result, an overflow flag (some part was saturated) and a divide-by-zero
// flag (divisor or inverted operand is zero; the result is then zero).
// Throughput: one transfer per cycle whenever busy is low. busy is high while reset is held
// and in the first cycle after reset.
// Every operation takes the same path, so results leave in the order the requests came in.
// The path is set by the quotient chain: one cell per quotient bit, after five front stages
// (capture, multiply, sum, magnitude and saturation, dividend scaling) and before the
// output register.
// The receiver cannot stall; results are presented once and never held back.
// Reset clears every valid bit in the pipeline; items in flight at reset are dropped.
`default_nettype none

module complex_arith_unit_core
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [TYPE_W-1:0]         req_type,
   input  logic signed [FIELD_W-1:0] req_a_re,
   input  logic signed [FIELD_W-1:0] req_a_im,
   input  logic signed [FIELD_W-1:0] req_b_re,
   input  logic signed [FIELD_W-1:0] req_b_im,
   output logic                      rsp_valid,
   output logic signed [FIELD_W-1:0] rsp_res_re,
   output logic signed [FIELD_W-1:0] rsp_res_im,
   output logic                      rsp_overflow,
   output logic                      rsp_div_by_zero
);

   // The arithmetic width is the configured width, capped at the port field width.
   localparam int OPW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int MW  = 2 * OPW;
   localparam int QB  = OPW + 1;
   localparam logic [QB-1:0] HQ = QB'(1) << (OPW - 1);

   // busy covers the time reset is held and the cycle right after reset.
   logic busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   assign busy = busy_ff;

   // Operand bits above the arithmetic width are ignored.
   logic                  accept;
   logic signed [OPW-1:0] a_re, a_im, b_re, b_im;

   assign accept = start && !busy_ff;
   assign a_re   = OPW'(req_a_re);
   assign a_im   = OPW'(req_a_im);
   assign b_re   = OPW'(req_b_re);
   assign b_im   = OPW'(req_b_im);

   // Chain links: index 0 is the front end output, index QB the last cell output.
   ctl_type               ch_ctl    [0:QB];
   logic [MW-1:0]         ch_den    [0:QB];
   logic [MW-1:0]         ch_rem_re [0:QB];
   logic [MW-1:0]         ch_rem_im [0:QB];
   logic [QB-1:0]         ch_xq_re  [0:QB];
   logic [QB-1:0]         ch_xq_im  [0:QB];
   logic signed [OPW-1:0] ch_res_re [0:QB];
   logic signed [OPW-1:0] ch_res_im [0:QB];

   cau_prep #(
      .OPW       (OPW),
      .FRAC_BITS (FRAC_BITS)
   ) u_prep (
      .clock    (clock),
      .reset    (reset),
      .in_valid (accept),
      .op_i     (op_type'(req_type)),
      .a_re_i   (a_re),
      .a_im_i   (a_im),
      .b_re_i   (b_re),
      .b_im_i   (b_im),
      .ctl_o    (ch_ctl[0]),
      .den_o    (ch_den[0]),
      .rem_re_o (ch_rem_re[0]),
      .rem_im_o (ch_rem_im[0]),
      .xq_re_o  (ch_xq_re[0]),
      .xq_im_o  (ch_xq_im[0]),
      .res_re_o (ch_res_re[0]),
      .res_im_o (ch_res_im[0])
   );

   // Each cell resolves one quotient bit for both parts, most significant bit first.
   for (genvar g = 0; g < QB; g++) begin : g_cell
      cau_cell #(
         .OPW (OPW)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl_i    (ch_ctl[g]),
         .den_i    (ch_den[g]),
         .rem_re_i (ch_rem_re[g]),
         .rem_im_i (ch_rem_im[g]),
         .xq_re_i  (ch_xq_re[g]),
         .xq_im_i  (ch_xq_im[g]),
         .res_re_i (ch_res_re[g]),
         .res_im_i (ch_res_im[g]),
         .ctl_o    (ch_ctl[g+1]),
         .den_o    (ch_den[g+1]),
         .rem_re_o (ch_rem_re[g+1]),
         .rem_im_o (ch_rem_im[g+1]),
         .xq_re_o  (ch_xq_re[g+1]),
         .xq_im_o  (ch_xq_im[g+1]),
         .res_re_o (ch_res_re[g+1]),
         .res_im_o (ch_res_im[g+1])
      );
   end

   // Saturate a quotient; the top bit of the result is the overflow flag. The early
   // overflow mark means the quotient did not fit the chain at all.
   function automatic logic [OPW:0] qsat_fn(input logic neg, input logic ovq,
                                            input logic [QB-1:0] q);
      logic [OPW:0] r;
      if (!neg) begin
         if (ovq || q > HQ - QB'(1)) begin
            r = {1'b1, OPW'(HQ - QB'(1))};
         end else begin
            r = {1'b0, q[OPW-1:0]};
         end
      end else begin
         if (ovq || q > HQ) begin
            r = {1'b1, OPW'(HQ)};
         end else begin
            r = {1'b0, OPW'(QB'(0) - q)};
         end
      end
      return r;
   endfunction

   ctl_type               fin;
   logic [OPW:0]          q_re, q_im;
   logic signed [OPW-1:0] out_re_in, out_im_in;
   logic                  ovf_in, dz_in;

   assign fin  = ch_ctl[QB];
   assign q_re = qsat_fn(fin.neg_re, fin.ovq_re, ch_xq_re[QB]);
   assign q_im = qsat_fn(fin.neg_im, fin.ovq_im, ch_xq_im[QB]);

   always_comb begin
      if (fin.dz) begin
         out_re_in = '0;
         out_im_in = '0;
         ovf_in    = 1'b0;
         dz_in     = 1'b1;
      end else if (fin.div) begin
         out_re_in = q_re[OPW-1:0];
         out_im_in = q_im[OPW-1:0];
         ovf_in    = q_re[OPW] | q_im[OPW];
         dz_in     = 1'b0;
      end else begin
         out_re_in = ch_res_re[QB];
         out_im_in = ch_res_im[QB];
         ovf_in    = fin.ovf;
         dz_in     = 1'b0;
      end
   end

   logic                  rsp_valid_ff, ovf_ff, dz_ff;
   logic signed [OPW-1:0] out_re_ff, out_im_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= fin.valid;
      end
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
      ovf_ff    <= ovf_in;
      dz_ff     <= dz_in;
   end

   // Results are sign-extended from the arithmetic width to the field width.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_res_re      = FIELD_W'(out_re_ff);
   assign rsp_res_im      = FIELD_W'(out_im_ff);
   assign rsp_overflow    = ovf_ff;
   assign rsp_div_by_zero = dz_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/cau_checker.sv =====
`default_nettype none

module cau_checker
   import cau_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic [TYPE_W-1:0]         req_type,
   input logic                      rsp_valid,
   input logic signed [FIELD_W-1:0] rsp_res_re,
   input logic signed [FIELD_W-1:0] rsp_res_im,
   input logic                      rsp_overflow,
   input logic                      rsp_div_by_zero
);

   localparam int OPW = (DATA_WIDTH < FIELD_W) ? DATA_WIDTH : FIELD_W;
   localparam int LAT = OPW + 7;

   // Every transfer in gives exactly one result after the fixed latency.
   a_resp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("transfer in without result after fixed latency");

   a_resp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without matching transfer in");

   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |->
         (rsp_res_re == '0 && rsp_res_im == '0 && !rsp_overflow))
      else $error("divide by zero result not cleared");

   a_mag_real: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(req_type, LAT) == OP_MAG) |->
         (rsp_res_im == '0 && !rsp_div_by_zero && rsp_res_re >= 0))
      else $error("squared magnitude result malformed");

   a_dz_only_div: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_div_by_zero) |->
         ($past(req_type, LAT) == OP_DIV || $past(req_type, LAT) == OP_INV))
      else $error("divide by zero flagged for a non-dividing operation");

endmodule

bind complex_arith_unit_core cau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_cau_checker (.*);

`default_nettype wire
